// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the probe RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/ihsp_pkg.sv =====
// Shared types, constants and helpers of the image header size probe.
package ihsp_pkg;

   localparam int unsigned PositionBitsDef = 32;
   localparam int unsigned LeadLen = 24;
   localparam int unsigned HdrLen = 12;

   localparam logic [7:0] MarkerPrefix = 8'hFF;
   localparam logic [7:0] SoiCode = 8'hD8;
   localparam logic [7:0] SofLoA = 8'hC0;
   localparam logic [7:0] SofHiA = 8'hC3;
   localparam logic [7:0] SofLoB = 8'hC9;
   localparam logic [7:0] SofHiB = 8'hCB;

   typedef enum logic [1:0] {
      PHASE_SCAN = 2'd0,
      PHASE_SOF  = 2'd1,
      PHASE_STOP = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FMT_NONE = 2'd0,
      FMT_JPEG = 2'd1,
      FMT_GIF  = 2'd2,
      FMT_PNG  = 2'd3
   } format_type;

   typedef logic [LeadLen-1:0][7:0] lead_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] height;
      logic [15:0] width;
   } jpeg_info_type;

   function automatic logic is_sof(logic [7:0] m);
      return ((m >= SofLoA) && (m <= SofHiA)) || ((m >= SofLoB) && (m <= SofHiB));
   endfunction

endpackage

// ===== rtl/core/ihsp_jpeg_scan.sv =====
// JPEG marker segment walker: collects each segment header and hops to the next.
`include "assert_macros.svh"

module ihsp_jpeg_scan #(
   parameter int unsigned POSITION_BITS = ihsp_pkg::PositionBitsDef
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic                      clear,
   input  logic                      pos_active,
   input  logic [POSITION_BITS-1:0]  position,
   input  logic [7:0]                data_byte,
   output ihsp_pkg::jpeg_info_type   info
);

   localparam logic [POSITION_BITS-1:0] StartReset = POSITION_BITS'(2);

   logic [POSITION_BITS-1:0]             start_ff, start_in, start_upd;
   logic [ihsp_pkg::HdrLen-1:0][7:0]     hdr_ff, hdr_in, hdr_wr;
   ihsp_pkg::phase_type                  phase_ff, phase_in, phase_upd;
   logic [POSITION_BITS:0]               diff, sum;
   logic [16:0]                          hop;
   logic                                 in_window;
   logic [3:0]                           off, shift;
   logic [4:0]                           src;

   always_comb begin
      diff      = {1'b0, position} - {1'b0, start_ff};
      in_window = pos_active && (phase_ff == ihsp_pkg::PHASE_SCAN) &&
                  !diff[POSITION_BITS] &&
                  (diff[POSITION_BITS-1:0] < POSITION_BITS'(ihsp_pkg::HdrLen));
      off       = diff[3:0];
      hdr_wr    = hdr_ff;
      if (in_window) begin
         hdr_wr[off] = data_byte;
      end
      hop       = 17'd2 + {1'b0, hdr_wr[2], hdr_wr[3]};
      sum       = {1'b0, start_ff} + (POSITION_BITS+1)'(hop);
      shift     = hop[3:0];
      src       = 5'd0;
      phase_upd = phase_ff;
      start_upd = start_ff;
      hdr_in    = hdr_wr;
      if (in_window && (off == 4'(ihsp_pkg::HdrLen - 1))) begin
         if (hdr_wr[0] != ihsp_pkg::MarkerPrefix) begin
            phase_upd = ihsp_pkg::PHASE_STOP;
         end else if (ihsp_pkg::is_sof(hdr_wr[1])) begin
            phase_upd = ihsp_pkg::PHASE_SOF;
         end else begin
            // saturate a hop past the position range; it is never reached
            start_upd = sum[POSITION_BITS] ? '1 : sum[POSITION_BITS-1:0];
            // short hop: keep the overlapping header bytes already received
            if (!sum[POSITION_BITS] && (hop < 17'(ihsp_pkg::HdrLen))) begin
               for (int i = 0; i < ihsp_pkg::HdrLen; i++) begin
                  src = 5'(i) + {1'b0, shift};
                  if (src < 5'(ihsp_pkg::HdrLen)) begin
                     hdr_in[i] = hdr_wr[src[3:0]];
                  end
               end
            end
         end
      end
      phase_in = clear ? ihsp_pkg::PHASE_SCAN : phase_upd;
      start_in = clear ? StartReset : start_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ihsp_pkg::PHASE_SCAN;
         start_ff <= StartReset;
      end else if (fire) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
      end
      if (fire) begin
         hdr_ff <= hdr_in;
      end
   end

   assign info.phase  = phase_upd;
   assign info.height = {hdr_wr[5], hdr_wr[6]};
   assign info.width  = {hdr_wr[7], hdr_wr[8]};

   `ASSERT_NEXT(a_sof_sticky, clock, reset,
      (phase_ff == ihsp_pkg::PHASE_SOF) && !(fire && clear),
      phase_ff == ihsp_pkg::PHASE_SOF)
   `ASSERT_NEXT(a_clear_restarts, clock, reset, fire && clear,
      (phase_ff == ihsp_pkg::PHASE_SCAN) && (start_ff == StartReset))

endmodule

// ===== rtl/core/ihsp_result_reg.sv =====
// Format decision from the leading bytes and the JPEG scan, into the result register.
`include "assert_macros.svh"

module ihsp_result_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    long_enough,
   input  ihsp_pkg::lead_type      lead,
   input  ihsp_pkg::jpeg_info_type jpeg,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [63:0]             rsp_tdata,   // width [31:0], height [63:32]
   output logic [7:0]              rsp_tuser    // found [0], format [2:1], zero [7:3]
);

   logic                 found_in, found_ff, valid_ff;
   ihsp_pkg::format_type fmt_in, fmt_ff;
   logic [31:0]          width_in, height_in, width_ff, height_ff;
   logic                 is_gif, is_png;

   always_comb begin
      is_gif = (lead[0] == 8'h47) && (lead[1] == 8'h49) && (lead[2] == 8'h46);
      is_png = (lead[0] == 8'h89) && (lead[1] == 8'h50) && (lead[2] == 8'h4E) &&
               (lead[3] == 8'h47) && (lead[4] == 8'h0D) && (lead[5] == 8'h0A) &&
               (lead[6] == 8'h1A) && (lead[7] == 8'h0A) && (lead[12] == 8'h49) &&
               (lead[13] == 8'h48) && (lead[14] == 8'h44) && (lead[15] == 8'h52);
      found_in  = 1'b0;
      fmt_in    = ihsp_pkg::FMT_NONE;
      width_in  = '0;
      height_in = '0;
      if (long_enough) begin
         if (lead[2] == ihsp_pkg::MarkerPrefix) begin
            if ((lead[0] == ihsp_pkg::MarkerPrefix) && (lead[1] == ihsp_pkg::SoiCode) &&
                (jpeg.phase == ihsp_pkg::PHASE_SOF)) begin
               found_in  = 1'b1;
               fmt_in    = ihsp_pkg::FMT_JPEG;
               width_in  = {16'd0, jpeg.width};
               height_in = {16'd0, jpeg.height};
            end
         end else if (is_gif) begin
            found_in  = 1'b1;
            fmt_in    = ihsp_pkg::FMT_GIF;
            width_in  = {16'd0, lead[7], lead[6]};
            height_in = {16'd0, lead[9], lead[8]};
         end else if (is_png) begin
            found_in  = 1'b1;
            fmt_in    = ihsp_pkg::FMT_PNG;
            width_in  = {lead[16], lead[17], lead[18], lead[19]};
            height_in = {lead[20], lead[21], lead[22], lead[23]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         found_ff  <= found_in;
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {height_ff, width_ff};
   assign rsp_tuser  = {5'd0, fmt_ff, found_ff};

   `ASSERT_IMPLY(a_not_found_zero, clock, reset, valid_ff && !found_ff,
      (fmt_ff == ihsp_pkg::FMT_NONE) && (width_ff == 32'd0) && (height_ff == 32'd0))
   `ASSERT_IMPLY(a_found_has_format, clock, reset, valid_ff && found_ff,
      fmt_ff != ihsp_pkg::FMT_NONE)

endmodule

// ===== rtl/core/image_header_size_probe.sv =====
// Image header size probe: finds JPEG, GIF or PNG dimensions in a byte stream.
//
// req channel: one file byte per transaction in req_tdata[7:0]; req_tlast marks
// the final byte of a file. rsp channel: exactly one transaction per file, issued
// for the byte carrying req_tlast: rsp_tuser[0] found, rsp_tuser[2:1] format
// (0 none, 1 JPEG, 2 GIF, 3 PNG), rsp_tdata[31:0] width, rsp_tdata[63:32] height.
// Bytes without req_tlast produce no rsp transaction.
// Throughput is one byte per cycle unless a final byte waits for the result
// register: each byte passes an input register, one level of compare/add/select
// logic that updates the position counter, the leading-byte store and the JPEG
// segment walker, and for the final byte the result register, which drives
// rsp_tvalid. When rsp_tready is low and a result is waiting, further non-final
// bytes keep flowing; the next final byte holds in the input register until
// the result register empties. After each file the position counter and the JPEG
// walker return to their reset values, ready for the next file. Synchronous reset
// clears all control state; no clearing pass is needed.
`include "assert_macros.svh"

module image_header_size_probe #(
   parameter int unsigned POSITION_BITS = ihsp_pkg::PositionBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte [7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // width [31:0], height [63:32]
   output logic [7:0]  rsp_tuser    // found [0], format [2:1], zero [7:3]
);

   localparam int unsigned LeadIdxBits = $clog2(ihsp_pkg::LeadLen);

   logic                     s1_valid_ff, s1_last_ff;
   logic [7:0]               s1_byte_ff;
   logic                     out_free, s1_fire, result_load;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_upd;
   logic                     pos_active, long_enough;
   ihsp_pkg::lead_type       lead_ff, lead_in;
   ihsp_pkg::jpeg_info_type  jpeg_info;

   assign out_free    = !rsp_tvalid || rsp_tready;
   assign s1_fire     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign result_load = s1_fire && s1_last_ff;

   always_comb begin
      pos_active  = (pos_ff != '1);
      pos_upd     = pos_active ? (pos_ff + POSITION_BITS'(1)) : pos_ff;
      pos_in      = s1_last_ff ? '0 : pos_upd;
      long_enough = (pos_upd >= POSITION_BITS'(ihsp_pkg::LeadLen));
      lead_in     = lead_ff;
      if (pos_active && (pos_ff < POSITION_BITS'(ihsp_pkg::LeadLen))) begin
         lead_in[pos_ff[LeadIdxBits-1:0]] = s1_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_fire) begin
            pos_ff <= pos_in;
         end
      end
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_fire) begin
         lead_ff <= lead_in;
      end
   end

   ihsp_jpeg_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_fire),
      .clear      (s1_last_ff),
      .pos_active (pos_active),
      .position   (pos_ff),
      .data_byte  (s1_byte_ff),
      .info       (jpeg_info)
   );

   ihsp_result_reg u_result (
      .clock       (clock),
      .reset       (reset),
      .load        (result_load),
      .long_enough (long_enough),
      .lead        (lead_in),
      .jpeg        (jpeg_info),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   `ASSERT_NEXT(a_last_gives_result, clock, reset, result_load, rsp_tvalid)
   `ASSERT_NEXT(a_last_clears_position, clock, reset, result_load, pos_ff == '0)
   `ASSERT_IMPLY(a_no_load_while_full, clock, reset, result_load, out_free)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the image header size probe: byte streams in, dimensions out.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PosLimit = (64'h1 << ihsp_pkg::PositionBitsDef) - 1;
   localparam int ImageMax = 2048;
   localparam logic [23:0] GifTag = "GIF";
   localparam logic [63:0] PngSignature = 64'h89504E470D0A1A0A;
   localparam logic [31:0] IhdrTag = "IHDR";

   typedef struct packed {
      logic                 found;
      ihsp_pkg::format_type fmt;
      logic [31:0]          width;
      logic [31:0]          height;
   } image_dims_type;

   localparam image_dims_type NotFound = '{1'b0, ihsp_pkg::FMT_NONE, 32'h0, 32'h0};

   typedef enum {
      FILE_NOISE,
      FILE_GIF,
      FILE_PNG,
      FILE_PNG_BAD_SIG,
      FILE_JPEG,
      FILE_JPEG_NO_SOF,
      FILE_JPEG_BAD_SOI,
      FILE_JPEG_BROKEN
   } file_kind_type;

   typedef struct {
      file_kind_type  kind;
      logic [7:0]     marker;
      int             segments;
      logic [31:0]    width;
      logic [31:0]    height;
      int             length;
      logic           typed;
      image_dims_type want;
   } file_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // data_byte [7:0]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // width [31:0], height [63:32]
   logic [7:0]  rsp_tuser;           // found [0], format [2:1], zero [7:3]

   // dimension sniffer state
   longint unsigned     byte_count;
   logic [7:0]          lead_bytes [ihsp_pkg::LeadLen];
   longint unsigned     seg_base;
   logic [7:0]          seg_hdr [ihsp_pkg::HdrLen];
   ihsp_pkg::phase_type walk_phase;

   image_dims_type pending_dims [$];
   image_dims_type rsp_want;
   logic           typed_valid = 1'b0;
   image_dims_type typed_dims;
   file_row_type   directed_rows [$];
   logic [7:0]     image_buf [ImageMax];
   int             image_len;
   int             fail_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             bytes_sent = 0;

   image_header_size_probe u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   task automatic clear_sniffer();
      byte_count = 0;
      seg_base = 2;
      walk_phase = ihsp_pkg::PHASE_SCAN;
      for (int i = 0; i < ihsp_pkg::LeadLen; i++) lead_bytes[i] = 8'h00;
      for (int i = 0; i < ihsp_pkg::HdrLen; i++) seg_hdr[i] = 8'h00;
   endtask

   // Act on a complete segment header: stop, lock onto SOF, or hop to the next segment.
   task automatic hop_segment();
      longint unsigned hop, nxt, step_len;
      if (seg_hdr[0] != ihsp_pkg::MarkerPrefix) begin
         walk_phase = ihsp_pkg::PHASE_STOP;
         return;
      end
      if ((seg_hdr[1] >= ihsp_pkg::SofLoA && seg_hdr[1] <= ihsp_pkg::SofHiA) ||
          (seg_hdr[1] >= ihsp_pkg::SofLoB && seg_hdr[1] <= ihsp_pkg::SofHiB)) begin
         walk_phase = ihsp_pkg::PHASE_SOF;
         return;
      end
      hop = 64'd2 + {48'h0, seg_hdr[2], seg_hdr[3]};
      nxt = (seg_base > PosLimit - hop) ? PosLimit : seg_base + hop;
      step_len = nxt - seg_base;
      // keep header bytes that already belong to the next segment
      for (longint unsigned i = 0; i + step_len < ihsp_pkg::HdrLen; i++)
         seg_hdr[i] = seg_hdr[i + step_len];
      seg_base = nxt;
   endtask

   task automatic sniff_byte(input logic [7:0] value, input logic eof,
                             output logic done, output image_dims_type dims);
      longint unsigned off;
      dims = NotFound;
      done = eof;
      if (byte_count < PosLimit) begin
         if (byte_count < ihsp_pkg::LeadLen) lead_bytes[byte_count] = value;
         if (walk_phase == ihsp_pkg::PHASE_SCAN && byte_count >= seg_base &&
             byte_count - seg_base < ihsp_pkg::HdrLen) begin
            off = byte_count - seg_base;
            seg_hdr[off] = value;
            if (off == ihsp_pkg::HdrLen - 1) hop_segment();
         end
         byte_count++;
      end
      if (!eof) return;
      if (byte_count >= ihsp_pkg::LeadLen) begin
         if (lead_bytes[2] == ihsp_pkg::MarkerPrefix) begin
            if (lead_bytes[0] == ihsp_pkg::MarkerPrefix &&
                lead_bytes[1] == ihsp_pkg::SoiCode &&
                walk_phase == ihsp_pkg::PHASE_SOF) begin
               dims.found = 1'b1;
               dims.fmt = ihsp_pkg::FMT_JPEG;
               dims.height = {16'h0, seg_hdr[5], seg_hdr[6]};
               dims.width = {16'h0, seg_hdr[7], seg_hdr[8]};
            end
         end else if ({lead_bytes[0], lead_bytes[1], lead_bytes[2]} == GifTag) begin
            dims.found = 1'b1;
            dims.fmt = ihsp_pkg::FMT_GIF;
            dims.width = {16'h0, lead_bytes[7], lead_bytes[6]};
            dims.height = {16'h0, lead_bytes[9], lead_bytes[8]};
         end else if ({lead_bytes[0], lead_bytes[1], lead_bytes[2], lead_bytes[3],
                       lead_bytes[4], lead_bytes[5], lead_bytes[6], lead_bytes[7]}
                         == PngSignature &&
                      {lead_bytes[12], lead_bytes[13], lead_bytes[14], lead_bytes[15]}
                         == IhdrTag) begin
            dims.found = 1'b1;
            dims.fmt = ihsp_pkg::FMT_PNG;
            dims.width = {lead_bytes[16], lead_bytes[17], lead_bytes[18], lead_bytes[19]};
            dims.height = {lead_bytes[20], lead_bytes[21], lead_bytes[22], lead_bytes[23]};
         end
      end
      clear_sniffer();
   endtask

   function automatic logic [31:0] rand_dim();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0000_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] rand_sof();
      int r;
      r = $urandom_range(0, 6);
      return (r < 4) ? ihsp_pkg::SofLoA + 8'(r) : ihsp_pkg::SofLoB + 8'(r - 4);
   endfunction

   task automatic add_row(input file_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // Lay out one file in image_buf; unused bytes stay random.
   task automatic build_image(input file_row_type row);
      int p, sof_at, seg_len, brk, j;
      logic [7:0] mk;
      for (int i = 0; i < ImageMax; i++) image_buf[i] = 8'($urandom);
      p = 0;
      sof_at = 0;
      brk = (row.kind == FILE_JPEG_BROKEN) ? $urandom_range(1, row.segments) : -1;
      case (row.kind)
         FILE_GIF: begin
            for (int i = 0; i < 3; i++) image_buf[i] = GifTag[23 - 8*i -: 8];
            image_buf[3] = "8";
            image_buf[4] = "9";
            image_buf[5] = "a";
            image_buf[6] = row.width[7:0];
            image_buf[7] = row.width[15:8];
            image_buf[8] = row.height[7:0];
            image_buf[9] = row.height[15:8];
            p = 10;
         end
         FILE_PNG, FILE_PNG_BAD_SIG: begin
            for (int i = 0; i < 8; i++) image_buf[i] = PngSignature[63 - 8*i -: 8];
            for (int i = 0; i < 4; i++) begin
               image_buf[8 + i] = (i == 3) ? 8'h0D : 8'h00;
               image_buf[12 + i] = IhdrTag[31 - 8*i -: 8];
               image_buf[16 + i] = row.width[31 - 8*i -: 8];
               image_buf[20 + i] = row.height[31 - 8*i -: 8];
            end
            if (row.kind == FILE_PNG_BAD_SIG) begin
               j = $urandom_range(0, 11);
               if (j >= 8) j = j + 4;
               image_buf[j] = image_buf[j] ^ 8'($urandom_range(1, 255));
            end
            p = 24;
         end
         FILE_NOISE: p = row.length;
         default: begin
            image_buf[0] = ihsp_pkg::MarkerPrefix;
            image_buf[1] = ihsp_pkg::SoiCode;
            p = 2;
            for (int k = 0; k < row.segments; k++) begin
               case ($urandom_range(0, 5))
                  0: mk = 8'hC4;
                  1: mk = 8'hC8;
                  2: mk = 8'hCC;
                  3: mk = 8'hDB;
                  4: mk = 8'hFE;
                  default: mk = 8'($urandom_range(8'hE0, 8'hEF));
               endcase
               j = $urandom_range(0, 19);
               seg_len = (j < 14) ? $urandom_range(2, 9) :
                         (j < 19) ? $urandom_range(10, 40) : $urandom_range(41, 300);
               image_buf[p] = (k == brk) ? 8'($urandom_range(0, 254))
                                         : ihsp_pkg::MarkerPrefix;
               image_buf[p + 1] = mk;
               image_buf[p + 2] = 8'(seg_len >> 8);
               image_buf[p + 3] = 8'(seg_len);
               p = p + 2 + seg_len;
            end
            sof_at = p;
            image_buf[p] = (brk == row.segments) ? 8'($urandom_range(0, 254))
                                                 : ihsp_pkg::MarkerPrefix;
            image_buf[p + 1] = row.marker;
            image_buf[p + 2] = 8'h00;
            image_buf[p + 3] = 8'h11;
            image_buf[p + 4] = 8'h08;
            image_buf[p + 5] = row.height[15:8];
            image_buf[p + 6] = row.height[7:0];
            image_buf[p + 7] = row.width[15:8];
            image_buf[p + 8] = row.width[7:0];
            image_buf[p + 9] = 8'h03;
            p = p + ihsp_pkg::HdrLen + $urandom_range(0, 6);
            if (row.kind == FILE_JPEG_BAD_SOI)
               image_buf[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
         end
      endcase
      if (row.kind == FILE_JPEG_NO_SOF)
         image_len = sof_at + $urandom_range(1, ihsp_pkg::HdrLen - 1);
      else if (row.kind == FILE_NOISE)
         image_len = p;
      else
         image_len = ((p < ihsp_pkg::LeadLen) ? ihsp_pkg::LeadLen : p) + $urandom_range(0, 8);
      if (row.length != 0) image_len = row.length;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic eof);
      logic done;
      image_dims_type dims;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sniff_byte(value, eof, done, dims);
      if (done) pending_dims.insert(pending_dims.size(), typed_valid ? typed_dims : dims);
      bytes_sent++;
   endtask

   task automatic send_image();
      for (int i = 0; i < image_len; i++) send_byte(image_buf[i], i == image_len - 1);
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_dims.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tuser %0h tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            rsp_want = pending_dims.pop_front();
            compare_field("found", 32'(rsp_want.found), 32'(rsp_tuser[0]));
            compare_field("format", 32'(rsp_want.fmt), 32'(rsp_tuser[2:1]));
            compare_field("width", rsp_want.width, rsp_tdata[31:0]);
            compare_field("height", rsp_want.height, rsp_tdata[63:32]);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      file_row_type row;
      int phase_start, pick;
      clear_sniffer();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row('{FILE_NOISE, 8'h00, 0, 32'h0, 32'h0, 1, 1'b1, NotFound});
      add_row('{FILE_NOISE, 8'h00, 0, 32'h0, 32'h0, 23, 1'b1, NotFound});
      add_row('{FILE_GIF, 8'h00, 0, 32'h0, 32'h0, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_GIF, 32'h0, 32'h0}});
      add_row('{FILE_GIF, 8'h00, 0, 32'hFFFF, 32'hFFFF, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_GIF, 32'hFFFF, 32'hFFFF}});
      add_row('{FILE_GIF, 8'h00, 0, 32'h1234, 32'h5678, 23, 1'b1, NotFound});
      add_row('{FILE_PNG, 8'h00, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_PNG, 32'hFFFF_FFFF, 32'hFFFF_FFFF}});
      add_row('{FILE_PNG, 8'h00, 0, 32'h0, 32'h0, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_PNG, 32'h0, 32'h0}});
      add_row('{FILE_PNG_BAD_SIG, 8'h00, 0, 640, 480, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, ihsp_pkg::SofLoA, 0, 32'hFFFF, 32'hFFFF, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_JPEG, 32'hFFFF, 32'hFFFF}});
      add_row('{FILE_JPEG, ihsp_pkg::SofLoA, 0, 32'h0, 32'h0, 0, 1'b1,
                '{1'b1, ihsp_pkg::FMT_JPEG, 32'h0, 32'h0}});
      add_row('{FILE_JPEG, 8'hC1, 1, 1920, 1080, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, 8'hC2, 2, 800, 600, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, ihsp_pkg::SofHiA, 0, 123, 45, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, ihsp_pkg::SofLoB, 1, 4096, 2160, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, 8'hCA, 0, 1, 1, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG, ihsp_pkg::SofHiB, 1, 320, 240, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG_NO_SOF, ihsp_pkg::SofLoA, 1, 64, 64, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG_BAD_SOI, ihsp_pkg::SofLoA, 0, 64, 48, 0, 1'b0, NotFound});
      add_row('{FILE_JPEG_BROKEN, ihsp_pkg::SofLoA, 1, 64, 48, 0, 1'b0, NotFound});
      add_row('{FILE_NOISE, 8'h00, 0, 32'h0, 32'h0, 40, 1'b0, NotFound});

      foreach (directed_rows[i]) begin
         typed_valid = directed_rows[i].typed;
         typed_dims = directed_rows[i].want;
         build_image(directed_rows[i]);
         send_image();
      end
      typed_valid = 1'b0;

      // random files: well-formed most of the time, broken or noise the rest
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 40) begin
            pick = $urandom_range(0, 99);
            row.kind = (pick < 30) ? FILE_JPEG :
                       (pick < 45) ? FILE_GIF :
                       (pick < 60) ? FILE_PNG :
                       (pick < 68) ? FILE_JPEG_NO_SOF :
                       (pick < 73) ? FILE_JPEG_BAD_SOI :
                       (pick < 80) ? FILE_JPEG_BROKEN :
                       (pick < 85) ? FILE_PNG_BAD_SIG : FILE_NOISE;
            row.marker = rand_sof();
            row.segments = (row.kind == FILE_JPEG_BROKEN) ? $urandom_range(1, 4)
                                                          : $urandom_range(0, 4);
            row.width = rand_dim();
            row.height = rand_dim();
            row.length = (row.kind == FILE_NOISE) ? $urandom_range(1, 64) : 0;
            row.typed = 1'b0;
            row.want = NotFound;
            build_image(row);
            if ($urandom_range(0, 99) < 6) image_len = $urandom_range(1, ihsp_pkg::LeadLen - 1);
            send_image();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dims.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
